// ----- hw/rtl/kesm_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kesm_pkg: shared types and constants
// Action codes, controller states, default sizes and the control group
// passed from the controller to the table memories.
// ----------------------------------------------------------------------------
package kesm_pkg;

  // Default table geometry
  localparam int KESM_TABLE_ENTRIES = 64;
  localparam int KESM_MAX_SEQ_LEN   = 8;

  // Fixed field widths of the beats
  localparam int ACTION_W   = 2;
  localparam int BYTE_W     = 8;
  localparam int ENTRY_IDX_W = 6;
  localparam int BYTE_POS_W = 3;
  localparam int ENTRY_LEN_W = 4;

  // Input action codes
  typedef enum logic [ACTION_W-1:0] {
    ACT_RECV   = 2'd0,
    ACT_SEQ_WR = 2'd1,
    ACT_ENT_WR = 2'd2
  } action_t;

  // Controller states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN_RD,
    ST_SCAN_EV,
    ST_MAT_RD,
    ST_MAT_EV,
    ST_EMIT
  } state_t;

  // Table access strobes
  typedef struct packed {
    logic seq_we;   // write one sequence byte
    logic ent_we;   // write entry length and key code
    logic rd_en;    // read entry and sequence byte
  } tbl_ctl_t;

endpackage

// ----- hw/rtl/key_escape_sequence_matcher_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// key_escape_sequence_matcher_unit: keyboard escape sequence key decoder
// Matches received bytes against a loadable table of key sequences and
// passes on plain characters or matched key codes.
// ----------------------------------------------------------------------------
// One beat is taken at a time. Table writes and unknown actions complete in
// the idle state. A received byte that starts a match scans every table
// entry, one memory read per entry in a read state and an evaluate state. A
// byte inside a match walks the candidate range, fetching one sequence byte
// per read and evaluate pair and stopping at the first entry whose buffered
// prefix matches; when no candidate is left it falls back to a full start
// scan. Matching speed is set by the single read port of the sequence memory.
// The result sits in an output register; a new beat is taken while it waits,
// and a further result holds the block until the register is free. Table
// state needs no clearing pass: entry valid bits clear at reset.
// ----------------------------------------------------------------------------
module key_escape_sequence_matcher_unit
  import kesm_pkg::*;
#(
  parameter int TABLE_ENTRIES    = KESM_TABLE_ENTRIES,
  parameter int MAX_SEQUENCE_LEN = KESM_MAX_SEQ_LEN
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [ACTION_W-1:0]    action,
  input  logic [BYTE_W-1:0]      data_byte,
  input  logic [ENTRY_IDX_W-1:0] entry_index,
  input  logic [BYTE_POS_W-1:0]  byte_position,
  input  logic [ENTRY_LEN_W-1:0] entry_length,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic                   is_key_code,
  output logic [BYTE_W-1:0]      value
);

  localparam int IDX_W = $clog2(TABLE_ENTRIES);
  localparam int POS_W = $clog2(MAX_SEQUENCE_LEN);
  localparam int CNT_W = $clog2(MAX_SEQUENCE_LEN + 1);

  tbl_ctl_t          ctl;
  logic [IDX_W-1:0]  wr_idx;
  logic [POS_W-1:0]  wr_pos;
  logic [BYTE_W-1:0] wr_data;
  logic [CNT_W-1:0]  wr_len;
  logic [IDX_W-1:0]  rd_idx;
  logic [POS_W-1:0]  rd_pos;
  logic [BYTE_W-1:0] rd_seq;
  logic [CNT_W-1:0]  rd_len;
  logic [BYTE_W-1:0] rd_code;

  // Sequencer
  kesm_ctrl #(
    .TABLE_ENTRIES    (TABLE_ENTRIES),
    .MAX_SEQUENCE_LEN (MAX_SEQUENCE_LEN)
  ) u_ctrl (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .action        (action),
    .data_byte     (data_byte),
    .entry_index   (entry_index),
    .byte_position (byte_position),
    .entry_length  (entry_length),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .is_key_code   (is_key_code),
    .value         (value),
    .ctl           (ctl),
    .wr_idx        (wr_idx),
    .wr_pos        (wr_pos),
    .wr_data       (wr_data),
    .wr_len        (wr_len),
    .rd_idx        (rd_idx),
    .rd_pos        (rd_pos),
    .rd_seq        (rd_seq),
    .rd_len        (rd_len),
    .rd_code       (rd_code)
  );

  // Table memories
  kesm_table #(
    .TABLE_ENTRIES    (TABLE_ENTRIES),
    .MAX_SEQUENCE_LEN (MAX_SEQUENCE_LEN)
  ) u_table (
    .clk     (clk),
    .rst     (rst),
    .ctl     (ctl),
    .wr_idx  (wr_idx),
    .wr_pos  (wr_pos),
    .wr_data (wr_data),
    .wr_len  (wr_len),
    .rd_idx  (rd_idx),
    .rd_pos  (rd_pos),
    .rd_seq  (rd_seq),
    .rd_len  (rd_len),
    .rd_code (rd_code)
  );

endmodule

// ----- hw/rtl/kesm_table.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kesm_table: key sequence table storage
// Sequence byte memory addressed by {entry, position}, entry memory holding
// length and key code, and per-entry valid bits so an unwritten entry reads
// as length zero. Reads are registered.
// ----------------------------------------------------------------------------
module kesm_table
  import kesm_pkg::*;
#(
  parameter int TABLE_ENTRIES    = KESM_TABLE_ENTRIES,
  parameter int MAX_SEQUENCE_LEN = KESM_MAX_SEQ_LEN,
  localparam int IDX_W = $clog2(TABLE_ENTRIES),
  localparam int POS_W = $clog2(MAX_SEQUENCE_LEN),
  localparam int CNT_W = $clog2(MAX_SEQUENCE_LEN + 1)
) (
  input  logic              clk,
  input  logic              rst,
  input  tbl_ctl_t          ctl,
  input  logic [IDX_W-1:0]  wr_idx,
  input  logic [POS_W-1:0]  wr_pos,
  input  logic [BYTE_W-1:0] wr_data,
  input  logic [CNT_W-1:0]  wr_len,
  input  logic [IDX_W-1:0]  rd_idx,
  input  logic [POS_W-1:0]  rd_pos,
  output logic [BYTE_W-1:0] rd_seq,
  output logic [CNT_W-1:0]  rd_len,
  output logic [BYTE_W-1:0] rd_code
);

  localparam int SEQ_DEPTH = TABLE_ENTRIES << POS_W;

  logic [BYTE_W-1:0]        seq_mem [SEQ_DEPTH];
  logic [CNT_W-1:0]         len_mem [TABLE_ENTRIES];
  logic [BYTE_W-1:0]        code_mem [TABLE_ENTRIES];
  logic [TABLE_ENTRIES-1:0] entry_valid;

  logic [CNT_W-1:0]         len_q;
  logic                     valid_q;

  // Sequence byte memory
  always_ff @(posedge clk) begin
    if (ctl.seq_we) begin
      seq_mem[{wr_idx, wr_pos}] <= wr_data;
    end
    if (ctl.rd_en) begin
      rd_seq <= seq_mem[{rd_idx, rd_pos}];
    end
  end

  // Entry memory: length and key code
  always_ff @(posedge clk) begin
    if (ctl.ent_we) begin
      len_mem[wr_idx]  <= wr_len;
      code_mem[wr_idx] <= wr_data;
    end
    if (ctl.rd_en) begin
      len_q   <= len_mem[rd_idx];
      rd_code <= code_mem[rd_idx];
    end
  end

  // Valid bits, cleared at reset; registered alongside the memory read
  always_ff @(posedge clk) begin
    if (rst) begin
      entry_valid <= '0;
      valid_q     <= 1'b0;
    end else begin
      if (ctl.ent_we) begin
        entry_valid[wr_idx] <= 1'b1;
      end
      if (ctl.rd_en) begin
        valid_q <= entry_valid[rd_idx];
      end
    end
  end

  // Unwritten entry reads as disabled
  assign rd_len = valid_q ? len_q : '0;

endmodule

// ----- hw/rtl/kesm_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kesm_ctrl: matching sequencer
// Decodes input beats, walks the table one read per step for the start scan
// and the prefix match, keeps the match buffer and candidate range, and
// drives the registered result beat.
// ----------------------------------------------------------------------------
module kesm_ctrl
  import kesm_pkg::*;
#(
  parameter int TABLE_ENTRIES    = KESM_TABLE_ENTRIES,
  parameter int MAX_SEQUENCE_LEN = KESM_MAX_SEQ_LEN,
  localparam int IDX_W = $clog2(TABLE_ENTRIES),
  localparam int POS_W = $clog2(MAX_SEQUENCE_LEN),
  localparam int CNT_W = $clog2(MAX_SEQUENCE_LEN + 1)
) (
  input  logic                   clk,
  input  logic                   rst,
  // input beat
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [ACTION_W-1:0]    action,
  input  logic [BYTE_W-1:0]      data_byte,
  input  logic [ENTRY_IDX_W-1:0] entry_index,
  input  logic [BYTE_POS_W-1:0]  byte_position,
  input  logic [ENTRY_LEN_W-1:0] entry_length,
  // result beat
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic                   is_key_code,
  output logic [BYTE_W-1:0]      value,
  // table port
  output tbl_ctl_t               ctl,
  output logic [IDX_W-1:0]       wr_idx,
  output logic [POS_W-1:0]       wr_pos,
  output logic [BYTE_W-1:0]      wr_data,
  output logic [CNT_W-1:0]       wr_len,
  output logic [IDX_W-1:0]       rd_idx,
  output logic [POS_W-1:0]       rd_pos,
  input  logic [BYTE_W-1:0]      rd_seq,
  input  logic [CNT_W-1:0]       rd_len,
  input  logic [BYTE_W-1:0]      rd_code
);

  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_ENTRIES - 1);
  localparam logic [CNT_W-1:0] MAX_CNT  = CNT_W'(MAX_SEQUENCE_LEN);

  // Control registers
  state_t            state, state_next;
  logic              matching, matching_next;
  logic [CNT_W-1:0]  count, count_next;
  logic [IDX_W-1:0]  first, first_next;
  logic [IDX_W-1:0]  last, last_next;
  logic [IDX_W-1:0]  idx, idx_next;
  logic [POS_W-1:0]  pos, pos_next;
  logic              hit, hit_next;
  logic              out_valid_next;

  // Payload registers
  logic [IDX_W-1:0]  lo, lo_next;
  logic [IDX_W-1:0]  hi, hi_next;
  logic [CNT_W-1:0]  lo_len, lo_len_next;
  logic [BYTE_W-1:0] lo_code, lo_code_next;
  logic [CNT_W-1:0]  cur_len, cur_len_next;
  logic [BYTE_W-1:0] cur_code, cur_code_next;
  logic [BYTE_W-1:0] rx_byte, rx_byte_next;
  logic              pend_key, pend_key_next;
  logic [BYTE_W-1:0] pend_val, pend_val_next;
  logic              is_key_code_next;
  logic [BYTE_W-1:0] value_next;
  logic [BYTE_W-1:0] match_buf [MAX_SEQUENCE_LEN];

  // Buffer write port
  logic              buf_we;
  logic [POS_W-1:0]  buf_wi;

  // Write decode helpers
  logic [8:0]        idx_wide;
  logic [4:0]        pos_wide;
  logic [4:0]        len_wide;
  logic [4:0]        len_sat;
  logic              idx_ok;
  logic              pos_ok;

  // Step helpers
  logic              scan_hit;
  logic              first_hit;
  logic              hit_f;
  logic [IDX_W-1:0]  lo_f;
  logic [IDX_W-1:0]  hi_f;
  logic [CNT_W-1:0]  lo_len_f;
  logic [BYTE_W-1:0] lo_code_f;
  logic [CNT_W-1:0]  len_e;
  logic [BYTE_W-1:0] code_e;
  logic              byte_ok;
  logic              pos_last;
  logic              range_end;
  logic              res_go;
  logic              res_key;
  logic [BYTE_W-1:0] res_val;
  logic              slot_free;

  // Table write fields
  assign idx_wide = 9'(entry_index);
  assign pos_wide = 5'(byte_position);
  assign len_wide = 5'(entry_length);
  assign len_sat  = (len_wide > 5'(MAX_SEQUENCE_LEN)) ? 5'(MAX_SEQUENCE_LEN) : len_wide;
  assign idx_ok   = idx_wide < 9'(TABLE_ENTRIES);
  assign pos_ok   = pos_wide < 5'(MAX_SEQUENCE_LEN);
  assign wr_idx   = idx_wide[IDX_W-1:0];
  assign wr_pos   = pos_wide[POS_W-1:0];
  assign wr_len   = len_sat[CNT_W-1:0];
  assign wr_data  = data_byte;

  assign rd_idx   = idx;
  assign rd_pos   = pos;

  // Start scan: range of enabled entries whose first byte is the new byte
  assign scan_hit  = (rd_len != '0) && (rd_seq == rx_byte);
  assign first_hit = scan_hit && !hit;
  assign hit_f     = hit || scan_hit;
  assign lo_f      = first_hit ? idx : lo;
  assign hi_f      = scan_hit ? idx : hi;
  assign lo_len_f  = first_hit ? rd_len : lo_len;
  assign lo_code_f = first_hit ? rd_code : lo_code;

  // Prefix match: length is fetched with byte zero of each entry
  assign len_e     = (pos == '0) ? rd_len : cur_len;
  assign code_e    = (pos == '0) ? rd_code : cur_code;
  assign byte_ok   = (len_e >= count) && (rd_seq == match_buf[pos]);
  assign pos_last  = (CNT_W'(pos) + CNT_W'(1)) == count;
  assign range_end = (idx == last) || (idx == LAST_IDX);

  assign slot_free = !out_valid || out_ready;

  // Next state and outputs
  always_comb begin
    state_next       = state;
    matching_next    = matching;
    count_next       = count;
    first_next       = first;
    last_next        = last;
    idx_next         = idx;
    pos_next         = pos;
    hit_next         = hit;
    lo_next          = lo;
    hi_next          = hi;
    lo_len_next      = lo_len;
    lo_code_next     = lo_code;
    cur_len_next     = cur_len;
    cur_code_next    = cur_code;
    rx_byte_next     = rx_byte;
    pend_key_next    = pend_key;
    pend_val_next    = pend_val;
    is_key_code_next = is_key_code;
    value_next       = value;
    out_valid_next   = out_valid && !out_ready;
    in_ready         = 1'b0;
    ctl              = '0;
    buf_we           = 1'b0;
    buf_wi           = '0;
    res_go           = 1'b0;
    res_key          = 1'b0;
    res_val          = rx_byte;

    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          case (action_t'(action))
            ACT_RECV: begin
              rx_byte_next = data_byte;
              if (!matching || count == '0 || count >= MAX_CNT) begin
                idx_next   = '0;
                pos_next   = '0;
                hit_next   = 1'b0;
                state_next = ST_SCAN_RD;
              end else begin
                buf_we     = 1'b1;
                buf_wi     = count[POS_W-1:0];
                count_next = count + CNT_W'(1);
                idx_next   = first;
                pos_next   = '0;
                state_next = ST_MAT_RD;
              end
            end
            ACT_SEQ_WR: begin
              ctl.seq_we = idx_ok && pos_ok;
            end
            ACT_ENT_WR: begin
              ctl.ent_we = idx_ok;
            end
            default: begin
            end
          endcase
        end
      end

      ST_SCAN_RD: begin
        ctl.rd_en  = 1'b1;
        pos_next   = '0;
        state_next = ST_SCAN_EV;
      end

      ST_SCAN_EV: begin
        hit_next     = hit_f;
        lo_next      = lo_f;
        hi_next      = hi_f;
        lo_len_next  = lo_len_f;
        lo_code_next = lo_code_f;
        if (idx == LAST_IDX) begin
          matching_next = 1'b0;
          count_next    = '0;
          state_next    = ST_IDLE;
          if (!hit_f) begin
            res_go  = 1'b1;
            res_key = 1'b0;
            res_val = rx_byte;
          end else begin
            first_next = lo_f;
            last_next  = hi_f;
            buf_we     = 1'b1;
            buf_wi     = '0;
            if (lo_len_f <= CNT_W'(1)) begin
              res_go  = 1'b1;
              res_key = 1'b1;
              res_val = lo_code_f;
            end else begin
              matching_next = 1'b1;
              count_next    = CNT_W'(1);
            end
          end
        end else begin
          idx_next   = idx + IDX_W'(1);
          state_next = ST_SCAN_RD;
        end
      end

      ST_MAT_RD: begin
        ctl.rd_en  = 1'b1;
        state_next = ST_MAT_EV;
      end

      ST_MAT_EV: begin
        cur_len_next  = len_e;
        cur_code_next = code_e;
        if (byte_ok && pos_last) begin
          // whole buffered prefix matches this entry
          first_next = idx;
          state_next = ST_IDLE;
          if (len_e <= count) begin
            matching_next = 1'b0;
            count_next    = '0;
            res_go        = 1'b1;
            res_key       = 1'b1;
            res_val       = code_e;
          end
        end else if (byte_ok) begin
          pos_next   = pos + POS_W'(1);
          state_next = ST_MAT_RD;
        end else if (range_end) begin
          // no candidate left: restart from this byte
          idx_next   = '0;
          pos_next   = '0;
          hit_next   = 1'b0;
          state_next = ST_SCAN_RD;
        end else begin
          idx_next   = idx + IDX_W'(1);
          pos_next   = '0;
          state_next = ST_MAT_RD;
        end
      end

      ST_EMIT: begin
        if (slot_free) begin
          out_valid_next   = 1'b1;
          is_key_code_next = pend_key;
          value_next       = pend_val;
          state_next       = ST_IDLE;
        end
      end

      default: begin
        state_next = ST_IDLE;
      end
    endcase

    // Result goes straight to the output register, or waits for it
    if (res_go) begin
      if (slot_free) begin
        out_valid_next   = 1'b1;
        is_key_code_next = res_key;
        value_next       = res_val;
      end else begin
        pend_key_next = res_key;
        pend_val_next = res_val;
        state_next    = ST_EMIT;
      end
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      matching  <= 1'b0;
      count     <= '0;
      first     <= '0;
      last      <= '0;
      idx       <= '0;
      pos       <= '0;
      hit       <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      matching  <= matching_next;
      count     <= count_next;
      first     <= first_next;
      last      <= last_next;
      idx       <= idx_next;
      pos       <= pos_next;
      hit       <= hit_next;
      out_valid <= out_valid_next;
    end
  end

  // Payload
  always_ff @(posedge clk) begin
    lo          <= lo_next;
    hi          <= hi_next;
    lo_len      <= lo_len_next;
    lo_code     <= lo_code_next;
    cur_len     <= cur_len_next;
    cur_code    <= cur_code_next;
    rx_byte     <= rx_byte_next;
    pend_key    <= pend_key_next;
    pend_val    <= pend_val_next;
    is_key_code <= is_key_code_next;
    value       <= value_next;
  end

  // Match buffer: the received byte lands at one slot per write
  always_ff @(posedge clk) begin
    if (buf_we) begin
      match_buf[buf_wi] <= (state == ST_IDLE) ? data_byte : rx_byte;
    end
  end

endmodule

// ----- dv/tb_key_escape_sequence_matcher_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_key_escape_sequence_matcher_unit: self-checking bench for the key decoder
// Loads key sequence tables and sends keystroke streams built from them,
// mostly whole sequences with random content, plus prefixes, broken sequences
// and plain bytes. A predictor updated at each accepted input beat queues the
// expected key codes and plain bytes, and each output beat is checked in order.
// Both sides stall at random, with one long output hold and one full drain.
// ----------------------------------------------------------------------------
module tb_key_escape_sequence_matcher_unit;
  import kesm_pkg::*;

  localparam int NUM_ENTRIES = KESM_TABLE_ENTRIES;
  localparam int SEQ_LEN     = KESM_MAX_SEQ_LEN;
  localparam logic [ACTION_W-1:0] ACT_NONE = 2'd3;  // unused code, block ignores it

  localparam int TOTAL_BEATS    = 1250;
  localparam int HOLD_AT        = 700;    // accepted beats before the long output hold
  localparam int HOLD_CYCLES    = 3000;
  localparam int DRAIN_AT       = 950;    // beat that waits for every result first
  localparam int WATCHDOG_LIMIT = 20000;
  localparam int TAIL_CYCLES    = 2500;

  typedef struct {
    logic [ACTION_W-1:0]    act;
    logic [BYTE_W-1:0]      data;
    logic [ENTRY_IDX_W-1:0] idx;
    logic [BYTE_POS_W-1:0]  pos;
    logic [ENTRY_LEN_W-1:0] len;
    bit                     drain;
  } beat_t;

  typedef struct {
    logic              is_key;
    logic [BYTE_W-1:0] val;
  } key_out_t;

  // DUT signals
  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [ACTION_W-1:0]    action = '0;
  logic [BYTE_W-1:0]      data_byte = '0;
  logic [ENTRY_IDX_W-1:0] entry_index = '0;
  logic [BYTE_POS_W-1:0]  byte_position = '0;
  logic [ENTRY_LEN_W-1:0] entry_length = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic is_key_code;
  logic [BYTE_W-1:0] value;

  key_escape_sequence_matcher_unit u_top (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .action        (action),
    .data_byte     (data_byte),
    .entry_index   (entry_index),
    .byte_position (byte_position),
    .entry_length  (entry_length),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .is_key_code   (is_key_code),
    .value         (value)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Predictor copy of the key table and match state
  logic [BYTE_W-1:0] tbl_seq [NUM_ENTRIES][SEQ_LEN];
  int                tbl_len [NUM_ENTRIES];
  logic [BYTE_W-1:0] tbl_code [NUM_ENTRIES];
  logic [BYTE_W-1:0] held_bytes [SEQ_LEN];
  int                held_count, cand_lo, cand_hi;
  bit                in_sequence;
  key_out_t          key_expected[$];

  // Table as seen by the stimulus generator, at the point reached in the queue
  logic [BYTE_W-1:0]  gen_seq [NUM_ENTRIES][SEQ_LEN];
  int                 gen_len [NUM_ENTRIES];
  logic [SEQ_LEN-1:0] gen_written [NUM_ENTRIES];
  beat_t              beat_q[$];

  int    n_total = TOTAL_BEATS;
  int    n_accepted = 0, n_expected = 0, n_seen = 0;
  int    fail_count = 0;
  int    send_gap, take_gap;
  int    hold_left = 0;
  bit    hold_done = 1'b0;
  int    idle_cycles = 0;
  int    got_result;
  beat_t cur_beat;

  // Start a fresh match on byte b, as from idle; returns 1 when a result is queued
  function automatic int begin_match(logic [BYTE_W-1:0] b);
    int  i, lo, hi;
    bit  hit;
    hit = 1'b0;
    lo  = 0;
    hi  = 0;
    for (i = 0; i < NUM_ENTRIES; i++) begin
      if (tbl_len[i] > 0 && tbl_seq[i][0] == b) begin
        if (!hit) lo = i;
        hi  = i;
        hit = 1'b1;
      end
    end
    in_sequence = 1'b0;
    held_count  = 0;
    if (!hit) begin
      key_expected.push_back('{1'b0, b});
      return 1;
    end
    cand_lo       = lo;
    cand_hi       = hi;
    held_bytes[0] = b;
    held_count    = 1;
    // one-byte entry: emits on the byte that starts it
    if (tbl_len[lo] <= 1) begin
      held_count = 0;
      key_expected.push_back('{1'b1, tbl_code[lo]});
      return 1;
    end
    in_sequence = 1'b1;
    return 0;
  endfunction

  // Apply one accepted input beat; returns the number of results it causes
  function automatic int decode_beat(beat_t bt);
    int i, k, ln;
    bit found, same;
    found = 1'b0;
    case (bt.act)
      ACT_RECV: begin
        if (!in_sequence || held_count == 0 || held_count >= SEQ_LEN)
          return begin_match(bt.data);
        held_bytes[held_count] = bt.data;
        held_count++;
        // narrow to the first candidate matching the whole buffered prefix
        for (i = cand_lo; i <= cand_hi && i < NUM_ENTRIES && !found; i++) begin
          if (tbl_len[i] >= held_count) begin
            same = 1'b1;
            for (k = 0; k < held_count; k++)
              if (tbl_seq[i][k] != held_bytes[k]) same = 1'b0;
            if (same) begin
              found   = 1'b1;
              cand_lo = i;
            end
          end
        end
        // no candidate left: drop the buffer, current byte restarts
        if (!found) return begin_match(bt.data);
        if (tbl_len[cand_lo] <= held_count) begin
          in_sequence = 1'b0;
          held_count  = 0;
          key_expected.push_back('{1'b1, tbl_code[cand_lo]});
          return 1;
        end
        return 0;
      end
      ACT_SEQ_WR: begin
        if (bt.idx < NUM_ENTRIES && bt.pos < SEQ_LEN) tbl_seq[bt.idx][bt.pos] = bt.data;
      end
      ACT_ENT_WR: begin
        if (bt.idx < NUM_ENTRIES) begin
          ln = bt.len;
          if (ln > SEQ_LEN) ln = SEQ_LEN;
          tbl_len[bt.idx]  = ln;
          tbl_code[bt.idx] = bt.data;
        end
      end
      default: ;
    endcase
    return 0;
  endfunction

  // Append a beat and track what it does to the table
  task automatic queue_beat(logic [ACTION_W-1:0] act, int data,
                            int idx, int pos, int len);
    beat_t bt;
    bt.act   = act;
    bt.data  = BYTE_W'(data);
    bt.idx   = ENTRY_IDX_W'(idx);
    bt.pos   = BYTE_POS_W'(pos);
    bt.len   = ENTRY_LEN_W'(len);
    bt.drain = (beat_q.size() == DRAIN_AT);
    if (act == ACT_SEQ_WR) begin
      gen_seq[idx][pos]     = BYTE_W'(data);
      gen_written[idx][pos] = 1'b1;
    end
    if (act == ACT_ENT_WR) gen_len[idx] = (len > SEQ_LEN) ? SEQ_LEN : len;
    beat_q.push_back(bt);
  endtask

  // Sequence bytes come from a small alphabet so entries share prefixes
  function automatic logic [BYTE_W-1:0] pick_seq_byte(int p);
    int r;
    r = $urandom_range(99);
    if (p == 0) begin
      if (r < 60) return 8'h1B;
      if (r < 80) return 8'h8F;
      return BYTE_W'($urandom_range(255));
    end
    if (r >= 70) return BYTE_W'($urandom_range(255));
    case ($urandom_range(5))
      0: return 8'h5B;
      1: return 8'h4F;
      2: return 8'h41;
      3: return 8'h42;
      4: return 8'h31;
      default: return 8'h7E;
    endcase
  endfunction

  // Zero, saturating and one-byte lengths show up often
  function automatic int pick_len();
    int r;
    r = $urandom_range(99);
    if (r < 10) return 0;
    if (r < 20) return $urandom_range(15, 9);
    if (r < 35) return 1;
    return $urandom_range(8, 2);
  endfunction

  // Load an entry; every position that can be compared is written before it is enabled
  task automatic load_entry(int e, int len, int code, bit fresh);
    int ln, p;
    ln = (len > SEQ_LEN) ? SEQ_LEN : len;
    for (p = 0; p < ln; p++)
      if (fresh || !gen_written[e][p])
        queue_beat(ACT_SEQ_WR, pick_seq_byte(p), e, p, $urandom_range(15));
    queue_beat(ACT_ENT_WR, code, e, $urandom_range(7), len);
  endtask

  // Table traffic that lands in the middle of keystroke streams
  task automatic table_noise();
    int r;
    r = $urandom_range(99);
    if (r < 40)
      load_entry($urandom_range(NUM_ENTRIES - 1), pick_len(), $urandom_range(255), 1'b1);
    else if (r < 70)
      queue_beat(ACT_SEQ_WR, pick_seq_byte($urandom_range(1)), $urandom_range(NUM_ENTRIES - 1),
                 $urandom_range(SEQ_LEN - 1), $urandom_range(15));
    else
      queue_beat(ACT_NONE, $urandom_range(255), $urandom_range(NUM_ENTRIES - 1),
                 $urandom_range(7), $urandom_range(15));
  endtask

  // Keystrokes: whole sequences, broken prefixes, or plain bytes
  task automatic send_keys();
    int e, n, p, r, tries;
    e     = $urandom_range(NUM_ENTRIES - 1);
    tries = 0;
    while (gen_len[e] == 0 && tries < NUM_ENTRIES) begin
      e = (e + 1) % NUM_ENTRIES;
      tries++;
    end
    r = $urandom_range(99);
    if (gen_len[e] == 0 || r < 15) begin
      n = $urandom_range(3, 1);
      for (p = 0; p < n; p++)
        queue_beat(ACT_RECV, $urandom_range(255), $urandom_range(NUM_ENTRIES - 1),
                   $urandom_range(7), $urandom_range(15));
    end else begin
      n = (r < 30) ? $urandom_range(gen_len[e], 1) : gen_len[e];
      for (p = 0; p < n; p++) begin
        if ($urandom_range(19) == 0) table_noise();
        queue_beat(ACT_RECV, gen_seq[e][p], $urandom_range(NUM_ENTRIES - 1),
                   $urandom_range(7), $urandom_range(15));
      end
      // broken sequence: a stray byte after the prefix
      if (r < 30)
        queue_beat(ACT_RECV, pick_seq_byte($urandom_range(n, 0)),
                   $urandom_range(NUM_ENTRIES - 1), $urandom_range(7), $urandom_range(15));
    end
  endtask

  // Idle rates by stage of the run
  always_comb begin
    if (n_accepted < n_total / 3) begin
      send_gap = 13;
      take_gap = 65;
    end else if (n_accepted < 2 * n_total / 3) begin
      send_gap = 65;
      take_gap = 13;
    end else begin
      send_gap = 0;
      take_gap = 0;
    end
  end

  // Input driver: predict on acceptance, then offer the next beat
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        got_result = decode_beat(cur_beat);
        n_accepted <= n_accepted + 1;
        n_expected <= n_expected + got_result;
      end
      if (!in_valid || in_ready) begin
        if (beat_q.size() > 0 && $urandom_range(99) >= send_gap &&
            (!beat_q[0].drain || (!in_valid && n_expected == n_seen))) begin
          cur_beat = beat_q.pop_front();
          action        <= cur_beat.act;
          data_byte     <= cur_beat.data;
          entry_index   <= cur_beat.idx;
          byte_position <= cur_beat.pos;
          entry_length  <= cur_beat.len;
          in_valid      <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Output monitor: check each result beat against the oldest expectation
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        n_seen <= n_seen + 1;
        if (key_expected.size() == 0) begin
          $error("unexpected result: is_key_code %0d value 0x%02h", is_key_code, value);
          fail_count++;
        end else begin
          if (is_key_code !== key_expected[0].is_key) begin
            $error("is_key_code: expected %0d, got %0d", key_expected[0].is_key, is_key_code);
            fail_count++;
          end
          if (value !== key_expected[0].val) begin
            $error("value: expected 0x%02h, got 0x%02h", key_expected[0].val, value);
            fail_count++;
          end
          void'(key_expected.pop_front());
        end
      end
      // one long hold lets the block fill up and stall its input
      if (!hold_done && n_accepted >= HOLD_AT) begin
        hold_done <= 1'b1;
        hold_left <= HOLD_CYCLES;
        out_ready <= 1'b0;
      end else if (hold_left > 0) begin
        hold_left <= hold_left - 1;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(99) >= take_gap);
      end
    end
  end

  // Watchdog on cycles without any beat moving
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    int e, p;
    for (e = 0; e < NUM_ENTRIES; e++) begin
      tbl_len[e]     = 0;
      tbl_code[e]    = '0;
      gen_len[e]     = 0;
      gen_written[e] = '0;
      for (p = 0; p < SEQ_LEN; p++) begin
        tbl_seq[e][p] = '0;
        gen_seq[e][p] = '0;
      end
    end
    for (p = 0; p < SEQ_LEN; p++) held_bytes[p] = '0;
    held_count  = 0;
    cand_lo     = 0;
    cand_hi     = 0;
    in_sequence = 1'b0;

    // Directed: plain bytes on an empty table and an ignored action
    queue_beat(ACT_RECV, 8'h00, 0, 0, 0);
    queue_beat(ACT_RECV, 8'hFF, 0, 0, 0);
    queue_beat(ACT_NONE, 8'hFF, 63, 7, 15);
    // one-byte entry
    queue_beat(ACT_SEQ_WR, 8'h7F, 0, 0, 0);
    queue_beat(ACT_ENT_WR, 8'h80, 0, 0, 1);
    queue_beat(ACT_RECV, 8'h7F, 0, 0, 0);
    // two entries sharing a prefix, one at the last index
    queue_beat(ACT_SEQ_WR, 8'h1B, 5, 0, 0);
    queue_beat(ACT_SEQ_WR, 8'h5B, 5, 1, 0);
    queue_beat(ACT_SEQ_WR, 8'h41, 5, 2, 0);
    queue_beat(ACT_ENT_WR, 8'h01, 5, 0, 3);
    queue_beat(ACT_SEQ_WR, 8'h1B, 63, 0, 0);
    queue_beat(ACT_SEQ_WR, 8'h5B, 63, 1, 0);
    queue_beat(ACT_SEQ_WR, 8'h42, 63, 2, 0);
    queue_beat(ACT_ENT_WR, 8'hFF, 63, 0, 3);
    // table write inside a match, then narrowing to the later entry
    queue_beat(ACT_RECV, 8'h1B, 0, 0, 0);
    queue_beat(ACT_ENT_WR, 8'h00, 0, 0, 0);
    queue_beat(ACT_RECV, 8'h5B, 0, 0, 0);
    queue_beat(ACT_RECV, 8'h42, 0, 0, 0);
    // mismatch on a plain byte, disabled entry
    queue_beat(ACT_RECV, 8'h1B, 0, 0, 0);
    queue_beat(ACT_RECV, 8'h5B, 0, 0, 0);
    queue_beat(ACT_RECV, 8'h44, 0, 0, 0);
    queue_beat(ACT_RECV, 8'h7F, 0, 0, 0);
    // mismatching byte that itself starts a new match
    queue_beat(ACT_RECV, 8'h1B, 0, 0, 0);
    queue_beat(ACT_RECV, 8'h1B, 0, 0, 0);
    queue_beat(ACT_RECV, 8'h5B, 0, 0, 0);
    queue_beat(ACT_RECV, 8'h41, 0, 0, 0);

    // Random: seed a table, then mostly keystroke streams
    for (e = 0; e < 8; e++)
      load_entry($urandom_range(NUM_ENTRIES - 1), $urandom_range(SEQ_LEN, 2),
                 $urandom_range(255), 1'b1);
    while (beat_q.size() < TOTAL_BEATS) begin
      p = $urandom_range(99);
      if (p < 18)
        load_entry($urandom_range(NUM_ENTRIES - 1), pick_len(), $urandom_range(255), 1'b1);
      else if (p < 24)
        table_noise();
      else
        send_keys();
    end
    n_total = beat_q.size();

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    do @(posedge clk); while (!(n_accepted == n_total && n_expected == n_seen));
    repeat (TAIL_CYCLES) @(posedge clk);
    if (key_expected.size() != 0) begin
      $error("%0d expected results never arrived", key_expected.size());
      fail_count++;
    end
    if (fail_count == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

endmodule

// ----- filelist.f -----
hw/rtl/kesm_pkg.sv
hw/rtl/kesm_table.sv
hw/rtl/kesm_ctrl.sv
hw/rtl/key_escape_sequence_matcher_unit.sv
dv/tb_key_escape_sequence_matcher_unit.sv
